/* design/plds_pkg.sv */
`timescale 1ns / 1ps
package plds_pkg;

  // Default number of fraction bits in a coordinate
  localparam int COORD_FRAC_BITS_DEF = 12;

  // Field widths
  localparam int COORD_W = 16;
  localparam int REFL_W  = 9;
  localparam int SHADE_W = 13;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  // Datapath widths
  localparam int PROD2_W = 32;  // one term of a cross product
  localparam int N_W     = 33;  // normal component, signed
  localparam int NMAG_W  = 32;  // normal component magnitude
  localparam int L_W     = 17;  // light vector component, signed
  localparam int LMAG_W  = 16;  // light vector component magnitude
  localparam int NSQ_W   = 64;
  localparam int LSQ_W   = 34;
  localparam int DOTT_W  = 50;  // one term of the dot product, signed
  localparam int DOT_W   = 52;
  localparam int DOTU_W  = 51;  // positive dot product
  localparam int ROOT_W  = NSQ_W / 2;
  localparam int LLEN_W  = LSQ_W / 2;
  localparam int DEN_W   = ROOT_W + LLEN_W;
  localparam int COS_Q_W = 18;
  localparam int COS_W   = 17;
  localparam int KDI_W   = REFL_W + CFG_W;
  localparam int PROD_W  = KDI_W + COS_W;
  localparam int SHADE_Q_W = 12;
  localparam int KD3_W   = 3 * REFL_W;

  localparam logic [COS_W-1:0]   COS_ONE   = COS_W'(65536);
  localparam logic [SHADE_W-1:0] SHADE_ONE = SHADE_W'(4096);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_POS_X     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_POS_Y     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_POS_Z     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_INTENSITY = CFG_IDX_W'(3);

  // Register reset values
  localparam logic [CFG_W-1:0] LIGHT_POS_X_RST     = CFG_W'(0);
  localparam logic [CFG_W-1:0] LIGHT_POS_Y_RST     = CFG_W'(12288);
  localparam logic [CFG_W-1:0] LIGHT_POS_Z_RST     = CFG_W'(12288);
  localparam logic [CFG_W-1:0] LIGHT_INTENSITY_RST = CFG_W'(5120);

endpackage

/* design/plds_sqrt_pipe.sv */
`timescale 1ns / 1ps
// Integer square root, one root bit per pipeline stage, floor result.
module plds_sqrt_pipe import plds_pkg::*; #(
  parameter int IN_W   = NSQ_W,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [IN_W-1:0]     in_rad,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_vld,
  output logic [IN_W/2-1:0]   out_root,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int OUT_W = IN_W / 2;
  localparam int R_W   = OUT_W + 2;

  logic              vld_r    [OUT_W];
  logic              vld_nxt  [OUT_W];
  logic [IN_W-1:0]   rad_r    [OUT_W];
  logic [IN_W-1:0]   rad_nxt  [OUT_W];
  logic [R_W-1:0]    rem_r    [OUT_W];
  logic [R_W-1:0]    rem_nxt  [OUT_W];
  logic [OUT_W-1:0]  root_r   [OUT_W];
  logic [OUT_W-1:0]  root_nxt [OUT_W];
  logic [SIDE_W-1:0] side_r   [OUT_W];
  logic [SIDE_W-1:0] side_nxt [OUT_W];

  always_comb begin
    logic              s_vld;
    logic [IN_W-1:0]   s_rad;
    logic [R_W-1:0]    s_rem;
    logic [OUT_W-1:0]  s_root;
    logic [SIDE_W-1:0] s_side;
    logic [R_W-1:0]    cand;
    logic [R_W-1:0]    trial;
    for (int k = 0; k < OUT_W; k++) begin
      if (k == 0) begin
        s_vld  = in_vld;
        s_rad  = in_rad;
        s_rem  = '0;
        s_root = '0;
        s_side = in_side;
      end else begin
        s_vld  = vld_r[k-1];
        s_rad  = rad_r[k-1];
        s_rem  = rem_r[k-1];
        s_root = root_r[k-1];
        s_side = side_r[k-1];
      end
      // bring down the next pair of radicand bits
      cand  = {s_rem[R_W-3:0], s_rad[IN_W-1 -: 2]};
      trial = {s_root, 2'b01};
      if (cand >= trial) begin
        rem_nxt[k]  = cand - trial;
        root_nxt[k] = {s_root[OUT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = cand;
        root_nxt[k] = {s_root[OUT_W-2:0], 1'b0};
      end
      rad_nxt[k]  = s_rad << 2;
      vld_nxt[k]  = s_vld;
      side_nxt[k] = s_side;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < OUT_W; k++) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_nxt[k];
      end
      rad_r[k]  <= rad_nxt[k];
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
      side_r[k] <= side_nxt[k];
    end
  end

  assign out_vld  = vld_r[OUT_W-1];
  assign out_root = root_r[OUT_W-1];
  assign out_side = side_r[OUT_W-1];

endmodule

/* design/plds_div_pipe.sv */
`timescale 1ns / 1ps
// Restoring division, one quotient bit per pipeline stage.
// Quotient is exact only while num < den * 2^Q_W.
module plds_div_pipe import plds_pkg::*; #(
  parameter int NUM_W  = 64,
  parameter int DEN_W  = plds_pkg::DEN_W,
  parameter int Q_W    = COS_Q_W,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [Q_W-1:0]    out_quo,
  output logic [SIDE_W-1:0] out_side
);

  localparam int CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic              vld_r    [Q_W];
  logic              vld_nxt  [Q_W];
  logic [CMP_W-1:0]  rem_r    [Q_W];
  logic [CMP_W-1:0]  rem_nxt  [Q_W];
  logic [DEN_W-1:0]  den_r    [Q_W];
  logic [DEN_W-1:0]  den_nxt  [Q_W];
  logic [Q_W-1:0]    quo_r    [Q_W];
  logic [Q_W-1:0]    quo_nxt  [Q_W];
  logic [SIDE_W-1:0] side_r   [Q_W];
  logic [SIDE_W-1:0] side_nxt [Q_W];

  always_comb begin
    logic              s_vld;
    logic [CMP_W-1:0]  s_rem;
    logic [DEN_W-1:0]  s_den;
    logic [Q_W-1:0]    s_quo;
    logic [SIDE_W-1:0] s_side;
    logic [CMP_W-1:0]  den_sh;
    for (int k = 0; k < Q_W; k++) begin
      if (k == 0) begin
        s_vld  = in_vld;
        s_rem  = CMP_W'(in_num);
        s_den  = in_den;
        s_quo  = '0;
        s_side = in_side;
      end else begin
        s_vld  = vld_r[k-1];
        s_rem  = rem_r[k-1];
        s_den  = den_r[k-1];
        s_quo  = quo_r[k-1];
        s_side = side_r[k-1];
      end
      den_sh = CMP_W'(s_den) << (Q_W - 1 - k);
      if (s_rem >= den_sh) begin
        rem_nxt[k] = s_rem - den_sh;
        quo_nxt[k] = s_quo | (Q_W'(1) << (Q_W - 1 - k));
      end else begin
        rem_nxt[k] = s_rem;
        quo_nxt[k] = s_quo;
      end
      den_nxt[k]  = s_den;
      vld_nxt[k]  = s_vld;
      side_nxt[k] = s_side;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < Q_W; k++) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_nxt[k];
      end
      rem_r[k]  <= rem_nxt[k];
      den_r[k]  <= den_nxt[k];
      quo_r[k]  <= quo_nxt[k];
      side_r[k] <= side_nxt[k];
    end
  end

  assign out_vld  = vld_r[Q_W-1];
  assign out_quo  = quo_r[Q_W-1];
  assign out_side = side_r[Q_W-1];

endmodule

/* design/point_light_diffuse_shader_core.sv */
`timescale 1ns / 1ps
// Throughput: one patch per cycle; busy never rises, so start may be held high.
// The depth is set mostly by the pipelined square roots (32 stages) and the
// cosine and shade dividers (18 and 12 stages), one result bit per stage.
// Reset (rst_n low, synchronous) drops every item in flight and restores the
// light registers; results cannot be held off by the receiver.
module point_light_diffuse_shader_core import plds_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  // patch input
  input  logic                        start,
  output logic                        busy,
  input  logic signed [COORD_W-1:0]   in_center_x,
  input  logic signed [COORD_W-1:0]   in_center_y,
  input  logic signed [COORD_W-1:0]   in_center_z,
  input  logic signed [COORD_W-1:0]   in_arm_u_x,
  input  logic signed [COORD_W-1:0]   in_arm_u_y,
  input  logic signed [COORD_W-1:0]   in_arm_u_z,
  input  logic signed [COORD_W-1:0]   in_arm_v_x,
  input  logic signed [COORD_W-1:0]   in_arm_v_y,
  input  logic signed [COORD_W-1:0]   in_arm_v_z,
  input  logic [REFL_W-1:0]           in_refl_red,
  input  logic [REFL_W-1:0]           in_refl_green,
  input  logic [REFL_W-1:0]           in_refl_blue,
  // shaded result
  output logic                        out_strobe,
  output logic [SHADE_W-1:0]          out_shade_red,
  output logic [SHADE_W-1:0]          out_shade_green,
  output logic [SHADE_W-1:0]          out_shade_blue,
  output logic                        out_lit
);

  // The final scale is prod * 2^(2F) / (|L|^2 * 2^20); fold it into one
  // left shift on whichever side needs it.
  localparam int NUM_SHIFT = (2 * COORD_FRAC_BITS >= 20) ? 2 * COORD_FRAC_BITS - 20 : 0;
  localparam int DEN_SHIFT = (2 * COORD_FRAC_BITS < 20) ? 20 - 2 * COORD_FRAC_BITS : 0;
  localparam int SNUM_W    = PROD_W + NUM_SHIFT;
  localparam int SDEN_W    = LSQ_W + DEN_SHIFT;
  localparam int SCMP_W    = (SNUM_W > SDEN_W + SHADE_Q_W) ? SNUM_W : SDEN_W + SHADE_Q_W;
  localparam int CNUM_W    = DOTU_W + 16;   // dot product scaled to Q.16
  localparam int CCMP_W    = DEN_W + 2;

  // ---------------------------------------------------------------------------
  // Light registers. Always ready; a write to an unknown index is dropped.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] light_x_r, light_y_r, light_z_r, light_int_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_x_r   <= LIGHT_POS_X_RST;
      light_y_r   <= LIGHT_POS_Y_RST;
      light_z_r   <= LIGHT_POS_Z_RST;
      light_int_r <= LIGHT_INTENSITY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LIGHT_POS_X:     light_x_r   <= cfg_data;
        REG_LIGHT_POS_Y:     light_y_r   <= cfg_data;
        REG_LIGHT_POS_Z:     light_z_r   <= cfg_data;
        REG_LIGHT_INTENSITY: light_int_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline never stalls, so a transfer is taken on every start.
  logic in_xfer;
  assign busy    = 1'b0;
  assign in_xfer = start && !busy;

  // ---------------------------------------------------------------------------
  // Stage 0: capture arms, form the light vector L = P - C.
  // ---------------------------------------------------------------------------
  logic                      s0_vld_r;
  logic signed [COORD_W-1:0] s0_ux_r, s0_uy_r, s0_uz_r, s0_vx_r, s0_vy_r, s0_vz_r;
  logic signed [L_W-1:0]     s0_lx_r, s0_ly_r, s0_lz_r;
  logic [KD3_W-1:0]          s0_kd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= in_xfer;
    end
    s0_ux_r <= in_arm_u_x;
    s0_uy_r <= in_arm_u_y;
    s0_uz_r <= in_arm_u_z;
    s0_vx_r <= in_arm_v_x;
    s0_vy_r <= in_arm_v_y;
    s0_vz_r <= in_arm_v_z;
    s0_lx_r <= L_W'($signed(light_x_r)) - L_W'(in_center_x);
    s0_ly_r <= L_W'($signed(light_y_r)) - L_W'(in_center_y);
    s0_lz_r <= L_W'($signed(light_z_r)) - L_W'(in_center_z);
    s0_kd_r <= {in_refl_blue, in_refl_green, in_refl_red};
  end

  // ---------------------------------------------------------------------------
  // Stage 1: the six products of the cross product U x V.
  // ---------------------------------------------------------------------------
  logic                      s1_vld_r;
  logic signed [PROD2_W-1:0] s1_p0_r, s1_p1_r, s1_p2_r, s1_p3_r, s1_p4_r, s1_p5_r;
  logic signed [L_W-1:0]     s1_lx_r, s1_ly_r, s1_lz_r;
  logic [KD3_W-1:0]          s1_kd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s0_vld_r;
    end
    s1_p0_r <= s0_uy_r * s0_vz_r;
    s1_p1_r <= s0_uz_r * s0_vy_r;
    s1_p2_r <= s0_uz_r * s0_vx_r;
    s1_p3_r <= s0_ux_r * s0_vz_r;
    s1_p4_r <= s0_ux_r * s0_vy_r;
    s1_p5_r <= s0_uy_r * s0_vx_r;
    s1_lx_r <= s0_lx_r;
    s1_ly_r <= s0_ly_r;
    s1_lz_r <= s0_lz_r;
    s1_kd_r <= s0_kd_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: normal N, exact with 2F fraction bits.
  // ---------------------------------------------------------------------------
  logic                  s2_vld_r;
  logic signed [N_W-1:0] s2_nx_r, s2_ny_r, s2_nz_r;
  logic signed [L_W-1:0] s2_lx_r, s2_ly_r, s2_lz_r;
  logic [KD3_W-1:0]      s2_kd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_nx_r <= N_W'(s1_p0_r) - N_W'(s1_p1_r);
    s2_ny_r <= N_W'(s1_p2_r) - N_W'(s1_p3_r);
    s2_nz_r <= N_W'(s1_p4_r) - N_W'(s1_p5_r);
    s2_lx_r <= s1_lx_r;
    s2_ly_r <= s1_ly_r;
    s2_lz_r <= s1_lz_r;
    s2_kd_r <= s1_kd_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: squares of N and L, terms of L . N.
  // ---------------------------------------------------------------------------
  logic [N_W-1:0]  nx_abs, ny_abs, nz_abs;
  logic [L_W-1:0]  lx_abs, ly_abs, lz_abs;

  assign nx_abs = s2_nx_r[N_W-1] ? -s2_nx_r : s2_nx_r;
  assign ny_abs = s2_ny_r[N_W-1] ? -s2_ny_r : s2_ny_r;
  assign nz_abs = s2_nz_r[N_W-1] ? -s2_nz_r : s2_nz_r;
  assign lx_abs = s2_lx_r[L_W-1] ? -s2_lx_r : s2_lx_r;
  assign ly_abs = s2_ly_r[L_W-1] ? -s2_ly_r : s2_ly_r;
  assign lz_abs = s2_lz_r[L_W-1] ? -s2_lz_r : s2_lz_r;

  logic                     s3_vld_r;
  logic [NSQ_W-1:0]         s3_nqx_r, s3_nqy_r, s3_nqz_r;
  logic [2*LMAG_W-1:0]      s3_lqx_r, s3_lqy_r, s3_lqz_r;
  logic signed [DOTT_W-1:0] s3_dx_r, s3_dy_r, s3_dz_r;
  logic [KD3_W-1:0]         s3_kd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_nqx_r <= nx_abs[NMAG_W-1:0] * nx_abs[NMAG_W-1:0];
    s3_nqy_r <= ny_abs[NMAG_W-1:0] * ny_abs[NMAG_W-1:0];
    s3_nqz_r <= nz_abs[NMAG_W-1:0] * nz_abs[NMAG_W-1:0];
    s3_lqx_r <= lx_abs[LMAG_W-1:0] * lx_abs[LMAG_W-1:0];
    s3_lqy_r <= ly_abs[LMAG_W-1:0] * ly_abs[LMAG_W-1:0];
    s3_lqz_r <= lz_abs[LMAG_W-1:0] * lz_abs[LMAG_W-1:0];
    s3_dx_r  <= s2_lx_r * s2_nx_r;
    s3_dy_r  <= s2_ly_r * s2_ny_r;
    s3_dz_r  <= s2_lz_r * s2_nz_r;
    s3_kd_r  <= s2_kd_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: |N|^2, |L|^2, L . N and the lit decision.
  // ---------------------------------------------------------------------------
  logic [NSQ_W-1:0]        nsq;
  logic [LSQ_W-1:0]        lsq;
  logic signed [DOT_W-1:0] dot;

  assign nsq = s3_nqx_r + s3_nqy_r + s3_nqz_r;
  assign lsq = LSQ_W'(s3_lqx_r) + LSQ_W'(s3_lqy_r) + LSQ_W'(s3_lqz_r);
  assign dot = DOT_W'(s3_dx_r) + DOT_W'(s3_dy_r) + DOT_W'(s3_dz_r);

  logic              s4_vld_r;
  logic [NSQ_W-1:0]  s4_nsq_r;
  logic [LSQ_W-1:0]  s4_lsq_r;
  logic [DOTU_W-1:0] s4_dot_r;
  logic              s4_alive_r;
  logic [KD3_W-1:0]  s4_kd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
    s4_nsq_r   <= nsq;
    s4_lsq_r   <= lsq;
    s4_dot_r   <= dot[DOTU_W-1:0];
    // zero normal, zero distance or facing away all give black
    s4_alive_r <= (nsq != '0) && (lsq != '0) && !dot[DOT_W-1] && (dot != '0);
    s4_kd_r    <= s3_kd_r;
  end

  // ---------------------------------------------------------------------------
  // Square roots of |N|^2 and |L|^2. Both units have the same depth so the
  // two roots arrive together; |L|^2 is zero-padded to the wider radicand.
  // ---------------------------------------------------------------------------
  logic                       rn_vld, rl_vld;
  logic [ROOT_W-1:0]          nlen, llen_w;
  logic [DOTU_W+KD3_W-1:0]    rn_side;
  logic [LSQ_W:0]             rl_side;

  plds_sqrt_pipe #(
    .IN_W   (NSQ_W),
    .SIDE_W (DOTU_W + KD3_W)
  ) u_sqrt_n (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s4_vld_r),
    .in_rad   (s4_nsq_r),
    .in_side  ({s4_dot_r, s4_kd_r}),
    .out_vld  (rn_vld),
    .out_root (nlen),
    .out_side (rn_side)
  );

  plds_sqrt_pipe #(
    .IN_W   (NSQ_W),
    .SIDE_W (LSQ_W + 1)
  ) u_sqrt_l (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s4_vld_r),
    .in_rad   (NSQ_W'(s4_lsq_r)),
    .in_side  ({s4_alive_r, s4_lsq_r}),
    .out_vld  (rl_vld),
    .out_root (llen_w),
    .out_side (rl_side)
  );

  // ---------------------------------------------------------------------------
  // Stage 5: den = floor|N| * floor|L|.
  // ---------------------------------------------------------------------------
  logic              s5_vld_r;
  logic [DEN_W-1:0]  s5_den_r;
  logic [DOTU_W-1:0] s5_dot_r;
  logic [KD3_W-1:0]  s5_kd_r;
  logic [LSQ_W-1:0]  s5_lsq_r;
  logic              s5_alive_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= rn_vld && rl_vld;
    end
    s5_den_r   <= nlen * llen_w[LLEN_W-1:0];
    s5_dot_r   <= rn_side[DOTU_W+KD3_W-1:KD3_W];
    s5_kd_r    <= rn_side[KD3_W-1:0];
    s5_lsq_r   <= rl_side[LSQ_W-1:0];
    s5_alive_r <= rl_side[LSQ_W];
  end

  // ---------------------------------------------------------------------------
  // Stage 6: flag a cosine of four or more, which the divider cannot hold.
  // ---------------------------------------------------------------------------
  logic              s6_vld_r;
  logic [DEN_W-1:0]  s6_den_r;
  logic [DOTU_W-1:0] s6_dot_r;
  logic [KD3_W-1:0]  s6_kd_r;
  logic [LSQ_W-1:0]  s6_lsq_r;
  logic              s6_alive_r;
  logic              s6_csat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else begin
      s6_vld_r <= s5_vld_r;
    end
    s6_den_r   <= s5_den_r;
    s6_dot_r   <= s5_dot_r;
    s6_kd_r    <= s5_kd_r;
    s6_lsq_r   <= s5_lsq_r;
    s6_alive_r <= s5_alive_r;
    s6_csat_r  <= CCMP_W'(s5_dot_r) >= (CCMP_W'(s5_den_r) << 2);
  end

  // ---------------------------------------------------------------------------
  // Cosine divider: floor(dot * 2^16 / den).
  // ---------------------------------------------------------------------------
  localparam int CSIDE_W = 2 + LSQ_W + KD3_W;

  logic               cd_vld;
  logic [COS_Q_W-1:0] cd_quo;
  logic [CSIDE_W-1:0] cd_side;

  plds_div_pipe #(
    .NUM_W  (CNUM_W),
    .DEN_W  (DEN_W),
    .Q_W    (COS_Q_W),
    .SIDE_W (CSIDE_W)
  ) u_div_cos (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s6_vld_r),
    .in_num   ({s6_dot_r, 16'd0}),
    .in_den   (s6_den_r),
    .in_side  ({s6_csat_r, s6_alive_r, s6_lsq_r, s6_kd_r}),
    .out_vld  (cd_vld),
    .out_quo  (cd_quo),
    .out_side (cd_side)
  );

  // ---------------------------------------------------------------------------
  // Stage 7: clamp cosine to 1.0, reflectance times intensity.
  // ---------------------------------------------------------------------------
  logic [KD3_W-1:0] cd_kd;
  logic             cd_csat;
  assign cd_kd   = cd_side[KD3_W-1:0];
  assign cd_csat = cd_side[CSIDE_W-1];

  logic             s7_vld_r;
  logic [COS_W-1:0] s7_cos_r;
  logic [KDI_W-1:0] s7_kdi_r [3];
  logic [LSQ_W-1:0] s7_lsq_r;
  logic             s7_alive_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else begin
      s7_vld_r <= cd_vld;
    end
    if (cd_csat || (cd_quo > COS_Q_W'(COS_ONE))) begin
      s7_cos_r <= COS_ONE;
    end else begin
      s7_cos_r <= cd_quo[COS_W-1:0];
    end
    for (int c = 0; c < 3; c++) begin
      s7_kdi_r[c] <= cd_kd[c*REFL_W +: REFL_W] * light_int_r;
    end
    s7_lsq_r   <= cd_side[KD3_W +: LSQ_W];
    s7_alive_r <= cd_side[CSIDE_W-2];
  end

  // ---------------------------------------------------------------------------
  // Stage 8: prod = kd * I * cos per channel.
  // ---------------------------------------------------------------------------
  logic              s8_vld_r;
  logic [PROD_W-1:0] s8_prod_r [3];
  logic [LSQ_W-1:0]  s8_lsq_r;
  logic              s8_alive_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_vld_r <= 1'b0;
    end else begin
      s8_vld_r <= s7_vld_r;
    end
    for (int c = 0; c < 3; c++) begin
      s8_prod_r[c] <= s7_kdi_r[c] * s7_cos_r;
    end
    s8_lsq_r   <= s7_lsq_r;
    s8_alive_r <= s7_alive_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 9: scale, and flag channels that reach 1.0.
  // ---------------------------------------------------------------------------
  logic [SNUM_W-1:0] snum [3];
  logic [SDEN_W-1:0] sden;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      snum[c] = SNUM_W'(s8_prod_r[c]) << NUM_SHIFT;
    end
    sden = SDEN_W'(s8_lsq_r) << DEN_SHIFT;
  end

  logic              s9_vld_r;
  logic [SNUM_W-1:0] s9_num_r [3];
  logic [SDEN_W-1:0] s9_den_r;
  logic [2:0]        s9_sat_r;
  logic              s9_alive_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_vld_r <= 1'b0;
    end else begin
      s9_vld_r <= s8_vld_r;
    end
    for (int c = 0; c < 3; c++) begin
      s9_num_r[c] <= snum[c];
      s9_sat_r[c] <= SCMP_W'(snum[c]) >= (SCMP_W'(sden) << SHADE_Q_W);
    end
    s9_den_r   <= sden;
    s9_alive_r <= s8_alive_r;
  end

  // ---------------------------------------------------------------------------
  // Shade dividers, one per colour channel.
  // ---------------------------------------------------------------------------
  logic                 sd_vld [3];
  logic [SHADE_Q_W-1:0] sd_quo [3];
  logic [1:0]           sd_side0;
  logic                 sd_sat1, sd_sat2;

  plds_div_pipe #(
    .NUM_W  (SNUM_W),
    .DEN_W  (SDEN_W),
    .Q_W    (SHADE_Q_W),
    .SIDE_W (2)
  ) u_div_red (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s9_vld_r),
    .in_num   (s9_num_r[0]),
    .in_den   (s9_den_r),
    .in_side  ({s9_alive_r, s9_sat_r[0]}),
    .out_vld  (sd_vld[0]),
    .out_quo  (sd_quo[0]),
    .out_side (sd_side0)
  );

  plds_div_pipe #(
    .NUM_W  (SNUM_W),
    .DEN_W  (SDEN_W),
    .Q_W    (SHADE_Q_W),
    .SIDE_W (1)
  ) u_div_green (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s9_vld_r),
    .in_num   (s9_num_r[1]),
    .in_den   (s9_den_r),
    .in_side  (s9_sat_r[1]),
    .out_vld  (sd_vld[1]),
    .out_quo  (sd_quo[1]),
    .out_side (sd_sat1)
  );

  plds_div_pipe #(
    .NUM_W  (SNUM_W),
    .DEN_W  (SDEN_W),
    .Q_W    (SHADE_Q_W),
    .SIDE_W (1)
  ) u_div_blue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s9_vld_r),
    .in_num   (s9_num_r[2]),
    .in_den   (s9_den_r),
    .in_side  (s9_sat_r[2]),
    .out_vld  (sd_vld[2]),
    .out_quo  (sd_quo[2]),
    .out_side (sd_sat2)
  );

  // ---------------------------------------------------------------------------
  // Output register: saturate at 1.0, force black when not lit.
  // ---------------------------------------------------------------------------
  logic               sd_alive;
  logic [2:0]         sd_sat;
  logic [SHADE_W-1:0] shade_nxt [3];

  assign sd_alive = sd_side0[1];
  assign sd_sat   = {sd_sat2, sd_sat1, sd_side0[0]};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (!sd_alive) begin
        shade_nxt[c] = '0;
      end else if (sd_sat[c]) begin
        shade_nxt[c] = SHADE_ONE;
      end else begin
        shade_nxt[c] = SHADE_W'(sd_quo[c]);
      end
    end
  end

  logic               out_vld_r;
  logic [SHADE_W-1:0] out_red_r, out_green_r, out_blue_r;
  logic               out_lit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= sd_vld[0] && sd_vld[1] && sd_vld[2];
    end
    out_red_r   <= shade_nxt[0];
    out_green_r <= shade_nxt[1];
    out_blue_r  <= shade_nxt[2];
    out_lit_r   <= sd_alive;
  end

  assign out_strobe      = out_vld_r;
  assign out_shade_red   = out_red_r;
  assign out_shade_green = out_green_r;
  assign out_shade_blue  = out_blue_r;
  assign out_lit         = out_lit_r;

endmodule
